// ----- rtl/core/bcc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int unsigned MAX_CLICKS = 4;
  localparam int unsigned CODE_W     = 3;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CODE_W-1:0] CODE_NONE  = '0;
  localparam logic [CODE_W-1:0] CODE_MAX   = CODE_W'(MAX_CLICKS);
  localparam logic [CODE_W-1:0] CODE_LONG  = CODE_W'(MAX_CLICKS + 1);
  localparam logic [CODE_W-1:0] CLICK_SAT  = CODE_W'(MAX_CLICKS - 1);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_LEVEL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_MIN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_ACTION = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_WINDOW = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POLL_PERIOD    = 3'd6;

  typedef struct packed {
    logic        idle_level;
    logic [7:0]  debounce_ms;
    logic [15:0] single_press_max_ms;
    logic [15:0] long_press_min_ms;
    logic [15:0] release_action_ms;
    logic [7:0]  release_window_ms;
    logic [7:0]  poll_period_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    idle_level:          1'b0,
    debounce_ms:         8'd20,
    single_press_max_ms: 16'd200,
    long_press_min_ms:   16'd500,
    release_action_ms:   16'd400,
    release_window_ms:   8'd10,
    poll_period_ms:      8'd25
  };

  typedef struct packed {
    logic              pin_level;
    logic [CODE_W-1:0] ack_action_code;
    logic              clear_duration_req;
    logic [TIME_W-1:0] clear_duration_min;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] action_code;
    logic [TIME_W-1:0] held_duration_ms;
    logic              pressed;
    logic              duration_cleared;
    logic              action_matched;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              poll_due;
  } tick_t;

endpackage

// ----- rtl/core/bcc_timebase.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_timebase
// Millisecond time count and poll period counter, advanced once per beat.
// ----------------------------------------------------------------------------
module bcc_timebase (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [7:0]            poll_period_ms,
  output bcc_pkg::tick_t        tick
);

  logic [bcc_pkg::TIME_W-1:0] now_ms;
  logic [7:0]                 poll_counter;
  logic [8:0]                 poll_inc;

  assign poll_inc      = {1'b0, poll_counter} + 9'd1;
  // period 0 acts as 1: the compare is true every beat
  assign tick.poll_due = poll_inc >= {1'b0, poll_period_ms};
  assign tick.now_ms   = now_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms       <= '0;
      poll_counter <= '0;
    end else if (advance) begin
      now_ms <= now_ms + 1'b1;
      if (tick.poll_due) begin
        poll_counter <= '0;
      end else begin
        poll_counter <= poll_inc[7:0];
      end
    end
  end

endmodule

// ----- rtl/core/bcc_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_core
// Debounce, level tracking, click classification and host acknowledgements.
// Computes one result per beat from the current state and commits the state.
// ----------------------------------------------------------------------------
module bcc_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  bcc_pkg::cfg_t        cfg,
  input  bcc_pkg::tick_t       tick,
  input  bcc_pkg::in_item_t    item,
  output bcc_pkg::out_item_t   result
);

  localparam int unsigned TW = bcc_pkg::TIME_W;
  localparam int unsigned CW = bcc_pkg::CODE_W;

  logic          prev_sample, prev_sample_next;
  logic [TW-1:0] last_edge_ms, last_edge_ms_next;
  logic          edge_flag, edge_flag_next;
  logic          level_now, level_now_next;
  logic          level_old, level_old_next;
  logic [TW-1:0] press_start_ms, press_start_ms_next;
  logic [TW-1:0] release_ms, release_ms_next;
  logic [TW-1:0] duration_ms, duration_ms_next;
  logic [TW-1:0] last_click_ms, last_click_ms_next;
  logic [CW-1:0] click_count, click_count_next;
  logic [CW-1:0] action_reg, action_reg_next;
  logic          matched, cleared;

  always_comb begin
    logic [TW-1:0] t;
    t = tick.now_ms;

    prev_sample_next    = item.pin_level;
    last_edge_ms_next   = last_edge_ms;
    edge_flag_next      = edge_flag;
    level_now_next      = level_now;
    level_old_next      = level_old;
    press_start_ms_next = press_start_ms;
    release_ms_next     = release_ms;
    duration_ms_next    = duration_ms;
    last_click_ms_next  = last_click_ms;
    click_count_next    = click_count;
    action_reg_next     = action_reg;
    matched             = 1'b0;
    cleared             = 1'b0;

    // debounced edge
    if (item.pin_level != prev_sample) begin
      if ((t - last_edge_ms) >= TW'(cfg.debounce_ms)) begin
        last_edge_ms_next = t;
        edge_flag_next    = 1'b1;
      end
    end

    if (tick.poll_due) begin
      // level tracking blocks while a held duration is pending
      if (duration_ms == '0 && edge_flag_next) begin
        level_now_next = item.pin_level;
        if (item.pin_level != level_old) begin
          level_old_next = item.pin_level;
          if (item.pin_level != cfg.idle_level) begin
            press_start_ms_next = t;
          end else begin
            duration_ms_next = t - press_start_ms;
            release_ms_next  = t;
          end
        end
        edge_flag_next = 1'b0;
      end

      if (action_reg == bcc_pkg::CODE_NONE) begin
        if (level_now_next == cfg.idle_level) begin
          if (duration_ms_next <= TW'(cfg.single_press_max_ms) &&
              (t - release_ms_next) < TW'(cfg.release_window_ms)) begin
            if (click_count < bcc_pkg::CLICK_SAT) begin
              click_count_next   = click_count + 1'b1;
              last_click_ms_next = t;
            end
          end else if (duration_ms_next >= TW'(cfg.long_press_min_ms)) begin
            action_reg_next = bcc_pkg::CODE_LONG;
          end
        end
        if ((t - last_click_ms_next) >= TW'(cfg.release_action_ms) &&
            action_reg_next == bcc_pkg::CODE_NONE) begin
          action_reg_next  = click_count_next;
          click_count_next = '0;
        end
      end
    end

    // host acknowledge: the max code and codes above long never match
    if (item.ack_action_code != bcc_pkg::CODE_MAX &&
        item.ack_action_code <= bcc_pkg::CODE_LONG &&
        action_reg_next == item.ack_action_code) begin
      matched         = 1'b1;
      action_reg_next = bcc_pkg::CODE_NONE;
    end

    if (item.clear_duration_req && duration_ms_next >= item.clear_duration_min) begin
      cleared          = 1'b1;
      duration_ms_next = '0;
    end
  end

  assign result.action_code      = action_reg_next;
  assign result.held_duration_ms = duration_ms_next;
  assign result.pressed          = level_now_next != cfg.idle_level;
  assign result.duration_cleared = cleared;
  assign result.action_matched   = matched;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample    <= 1'b0;
      last_edge_ms   <= '0;
      edge_flag      <= 1'b0;
      level_now      <= 1'b0;
      level_old      <= 1'b0;
      press_start_ms <= '0;
      release_ms     <= '0;
      duration_ms    <= '0;
      last_click_ms  <= '0;
      click_count    <= '0;
      action_reg     <= bcc_pkg::CODE_NONE;
    end else if (advance) begin
      prev_sample    <= prev_sample_next;
      last_edge_ms   <= last_edge_ms_next;
      edge_flag      <= edge_flag_next;
      level_now      <= level_now_next;
      level_old      <= level_old_next;
      press_start_ms <= press_start_ms_next;
      release_ms     <= release_ms_next;
      duration_ms    <= duration_ms_next;
      last_click_ms  <= last_click_ms_next;
      click_count    <= click_count_next;
      action_reg     <= action_reg_next;
    end
  end

endmodule

// ----- rtl/core/button_click_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_classifier
// Push button classifier: debounce, click counting, long press and held
// duration reporting, one result beat per input tick beat.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid / in_ready | pin_level, ack_action_code,
//          |                     | clear_duration_req, clear_duration_min
//  out     | out_valid/out_ready | action_code, held_duration_ms, pressed,
//          |                     | duration_cleared, action_matched
//  cfg     | cfg_we              | cfg_index, cfg_data
//
//  A beat accepted at an edge sits in the input register; its result moves
//  to the result register once it is free or drained, offered from then on.
//  One beat is taken per cycle while out_ready is high; the state update
//  between the two registers is one pass.
//  A stalled result freezes the pass: once the input register holds a beat,
//  in_ready stays low until the result beat is taken.
//  Synchronous reset clears state, config returns to defaults.
// ----------------------------------------------------------------------------
module button_click_classifier (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bcc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             pin_level,
  input  logic [bcc_pkg::CODE_W-1:0]       ack_action_code,
  input  logic                             clear_duration_req,
  input  logic [bcc_pkg::TIME_W-1:0]       clear_duration_min,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bcc_pkg::CODE_W-1:0]       action_code,
  output logic [bcc_pkg::TIME_W-1:0]       held_duration_ms,
  output logic                             pressed,
  output logic                             duration_cleared,
  output logic                             action_matched
);

  bcc_pkg::cfg_t      cfg;
  bcc_pkg::in_item_t  in_reg;
  bcc_pkg::out_item_t result, out_reg;
  bcc_pkg::tick_t     tick;
  logic               in_reg_valid;
  logic               advance;

  assign advance  = in_reg_valid && (!out_valid || out_ready);
  assign in_ready = !in_reg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= bcc_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcc_pkg::REG_IDLE_LEVEL:     cfg.idle_level          <= cfg_data[0];
        bcc_pkg::REG_DEBOUNCE:       cfg.debounce_ms         <= cfg_data[7:0];
        bcc_pkg::REG_SINGLE_MAX:     cfg.single_press_max_ms <= cfg_data;
        bcc_pkg::REG_LONG_MIN:       cfg.long_press_min_ms   <= cfg_data;
        bcc_pkg::REG_RELEASE_ACTION: cfg.release_action_ms   <= cfg_data;
        bcc_pkg::REG_RELEASE_WINDOW: cfg.release_window_ms   <= cfg_data[7:0];
        bcc_pkg::REG_POLL_PERIOD:    cfg.poll_period_ms      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg.pin_level          <= pin_level;
      in_reg.ack_action_code    <= ack_action_code;
      in_reg.clear_duration_req <= clear_duration_req;
      in_reg.clear_duration_min <= clear_duration_min;
    end
  end

  bcc_timebase u_timebase (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .poll_period_ms (cfg.poll_period_ms),
    .tick           (tick)
  );

  bcc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cfg     (cfg),
    .tick    (tick),
    .item    (in_reg),
    .result  (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= result;
    end
  end

  assign action_code      = out_reg.action_code;
  assign held_duration_ms = out_reg.held_duration_ms;
  assign pressed          = out_reg.pressed;
  assign duration_cleared = out_reg.duration_cleared;
  assign action_matched   = out_reg.action_matched;

endmodule

// ----- rtl/core/bcc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_checker
// Port-level checks for the button click classifier, bound to the top level.
// ----------------------------------------------------------------------------
module bcc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bcc_pkg::CODE_W-1:0]  action_code,
  input logic [bcc_pkg::TIME_W-1:0]  held_duration_ms,
  input logic                        duration_cleared,
  input logic                        action_matched
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(action_code) &&
      $stable(held_duration_ms))
    else $error("result beat changed while stalled");

  // acknowledge always leaves no action stored
  a_match_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && action_matched |-> action_code == bcc_pkg::CODE_NONE)
    else $error("matched ack left an action stored");

  // successful clear leaves zero duration
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && duration_cleared |-> held_duration_ms == '0)
    else $error("cleared duration is not zero");

  // click count saturates one below the max, so that code never appears
  a_no_max_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> action_code != bcc_pkg::CODE_MAX)
    else $error("action code equals the saturation code");

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .action_code      (action_code),
  .held_duration_ms (held_duration_ms),
  .duration_cleared (duration_cleared),
  .action_matched   (action_matched)
);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the button click classifier. Ticks go in over the
// valid/ready input with bursty pacing, and results drain through a stalling
// receiver. A tick-accurate predictor of the classifier (debounce, poll
// pass, click counting, long press, acks and duration clears) queues one
// expected result per accepted tick. The checker compares each result beat
// with the oldest entry in that queue. The bench runs several configurations,
// including the register extremes.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [bcc_pkg::CODE_W-1:0] CODE_ONE_CLICK  = bcc_pkg::CODE_W'(1);
  localparam logic [bcc_pkg::CODE_W-1:0] CODE_TWO_CLICKS = bcc_pkg::CODE_W'(2);
  localparam logic [bcc_pkg::CODE_W-1:0] ACK_BAD_LOW     =
    bcc_pkg::CODE_LONG + bcc_pkg::CODE_W'(1);
  localparam logic [bcc_pkg::CODE_W-1:0] ACK_BAD_HIGH    =
    bcc_pkg::CODE_LONG + bcc_pkg::CODE_W'(2);

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [bcc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bcc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           pin_level = 1'b0;
  logic [bcc_pkg::CODE_W-1:0]     ack_action_code = '0;
  logic                           clear_duration_req = 1'b0;
  logic [bcc_pkg::TIME_W-1:0]     clear_duration_min = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [bcc_pkg::CODE_W-1:0]     action_code;
  logic [bcc_pkg::TIME_W-1:0]     held_duration_ms;
  logic                           pressed;
  logic                           duration_cleared;
  logic                           action_matched;

  button_click_classifier dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .pin_level(pin_level), .ack_action_code(ack_action_code),
    .clear_duration_req(clear_duration_req), .clear_duration_min(clear_duration_min),
    .out_valid(out_valid), .out_ready(out_ready),
    .action_code(action_code), .held_duration_ms(held_duration_ms),
    .pressed(pressed), .duration_cleared(duration_cleared),
    .action_matched(action_matched)
  );

  always #5 clk = ~clk;

  // predictor state
  bcc_pkg::cfg_t              cur_cfg;
  logic [bcc_pkg::TIME_W-1:0] p_time, p_edge_t, p_press_t, p_release_t, p_held, p_click_t;
  logic                       p_last_sample, p_edge_pending, p_level, p_level_prev;
  logic [bcc_pkg::CODE_W-1:0] p_clicks, p_action;
  logic [7:0]                 p_poll_cnt;

  bcc_pkg::out_item_t report_q[$];

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int burst_left = 1;
  int n_configs = 0;
  int n_click_acks = 0;
  int n_long_acks = 0;
  int n_clears = 0;
  int cycle_cnt = 0;
  logic [5:0] stall_phase = '0;
  logic [1:0] stall_mode = '0;
  bcc_pkg::out_item_t got, want;

  function void log_failure(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endfunction

  function void reset_prediction();
    cur_cfg        = bcc_pkg::CFG_RESET;
    p_time         = '0;
    p_edge_t       = '0;
    p_press_t      = '0;
    p_release_t    = '0;
    p_held         = '0;
    p_click_t      = '0;
    p_last_sample  = bcc_pkg::CFG_RESET.idle_level;
    p_edge_pending = 1'b0;
    p_level        = 1'b0;
    p_level_prev   = 1'b0;
    p_clicks       = bcc_pkg::CODE_NONE;
    p_action       = bcc_pkg::CODE_NONE;
    p_poll_cnt     = '0;
  endfunction

  // advances the predicted classifier by one tick and returns its result
  function bcc_pkg::out_item_t classify_tick(input bcc_pkg::in_item_t it);
    logic [bcc_pkg::TIME_W-1:0] t;
    bcc_pkg::out_item_t r;
    t = p_time;
    r = '0;
    if (it.pin_level != p_last_sample &&
        (t - p_edge_t) >= bcc_pkg::TIME_W'(cur_cfg.debounce_ms)) begin
      p_edge_t = t;
      p_edge_pending = 1'b1;
    end
    p_last_sample = it.pin_level;

    if ({1'b0, p_poll_cnt} + 9'd1 >= {1'b0, cur_cfg.poll_period_ms}) begin
      p_poll_cnt = '0;
      // level tracking is frozen while a held duration is pending
      if (p_held == '0 && p_edge_pending) begin
        p_level = it.pin_level;
        if (p_level != p_level_prev) begin
          p_level_prev = p_level;
          if (p_level != cur_cfg.idle_level) begin
            p_press_t = t;
          end else begin
            p_held = t - p_press_t;
            p_release_t = t;
          end
        end
        p_edge_pending = 1'b0;
      end
      if (p_action == bcc_pkg::CODE_NONE) begin
        if (p_level == cur_cfg.idle_level) begin
          if (p_held <= bcc_pkg::TIME_W'(cur_cfg.single_press_max_ms) &&
              (t - p_release_t) < bcc_pkg::TIME_W'(cur_cfg.release_window_ms)) begin
            if (p_clicks < bcc_pkg::CLICK_SAT) begin
              p_clicks = p_clicks + bcc_pkg::CODE_W'(1);
              p_click_t = t;
            end
          end else if (p_held >= bcc_pkg::TIME_W'(cur_cfg.long_press_min_ms)) begin
            p_action = bcc_pkg::CODE_LONG;
          end
        end
        if ((t - p_click_t) >= bcc_pkg::TIME_W'(cur_cfg.release_action_ms) &&
            p_action == bcc_pkg::CODE_NONE) begin
          p_action = p_clicks;
          p_clicks = bcc_pkg::CODE_NONE;
        end
      end
    end else begin
      p_poll_cnt = p_poll_cnt + 8'd1;
    end

    if (it.ack_action_code != bcc_pkg::CODE_MAX &&
        it.ack_action_code <= bcc_pkg::CODE_LONG &&
        p_action == it.ack_action_code) begin
      r.action_matched = 1'b1;
      p_action = bcc_pkg::CODE_NONE;
    end
    if (it.clear_duration_req && p_held >= it.clear_duration_min) begin
      r.duration_cleared = 1'b1;
      p_held = '0;
    end
    r.action_code      = p_action;
    r.held_duration_ms = p_held;
    r.pressed          = (p_level != cur_cfg.idle_level);
    p_time = t + bcc_pkg::TIME_W'(1);
    return r;
  endfunction

  // one tick beat; valid stays up across a burst, then drops for a random gap
  task automatic send_tick(input logic pin, input logic [bcc_pkg::CODE_W-1:0] ack,
                           input logic req, input logic [bcc_pkg::TIME_W-1:0] thr);
    bcc_pkg::in_item_t  it;
    bcc_pkg::out_item_t r;
    it.pin_level          = pin;
    it.ack_action_code    = ack;
    it.clear_duration_req = req;
    it.clear_duration_min = thr;
    in_valid           <= 1'b1;
    pin_level          <= pin;
    ack_action_code    <= ack;
    clear_duration_req <= req;
    clear_duration_min <= thr;
    do @(posedge clk); while (!in_ready);
    r = classify_tick(it);
    report_q.push_back(r);
    items_sent++;
    if (r.action_matched && ack == bcc_pkg::CODE_LONG) n_long_acks++;
    else if (r.action_matched && ack != bcc_pkg::CODE_NONE) n_click_acks++;
    if (r.duration_cleared) n_clears++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
    end
  endtask

  // host side: acks the stored action in a third of ticks, clears near the held duration
  task automatic send_host(input logic pin);
    logic [bcc_pkg::CODE_W-1:0] ack;
    logic                       req;
    logic [bcc_pkg::TIME_W-1:0] thr;
    case ($urandom_range(0, 5))
      0, 1:    ack = p_action;
      2:       ack = bcc_pkg::CODE_W'($urandom_range(0, 7));
      default: ack = bcc_pkg::CODE_MAX;
    endcase
    req = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 5))
      0:       thr = '0;
      1:       thr = p_held;
      2:       thr = p_held + bcc_pkg::TIME_W'(1);
      3:       thr = $urandom;
      default: thr = p_held >> 1;
    endcase
    send_tick(pin, ack, req, thr);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(input bcc_pkg::cfg_t c);
    logic [bcc_pkg::CFG_IDX_W-1:0]  idx  [7];
    logic [bcc_pkg::CFG_DATA_W-1:0] vals [7];
    int i;
    idx  = '{bcc_pkg::REG_IDLE_LEVEL, bcc_pkg::REG_DEBOUNCE, bcc_pkg::REG_SINGLE_MAX,
             bcc_pkg::REG_LONG_MIN, bcc_pkg::REG_RELEASE_ACTION,
             bcc_pkg::REG_RELEASE_WINDOW, bcc_pkg::REG_POLL_PERIOD};
    vals = '{bcc_pkg::CFG_DATA_W'(c.idle_level), bcc_pkg::CFG_DATA_W'(c.debounce_ms),
             c.single_press_max_ms, c.long_press_min_ms, c.release_action_ms,
             bcc_pkg::CFG_DATA_W'(c.release_window_ms),
             bcc_pkg::CFG_DATA_W'(c.poll_period_ms)};
    for (i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_cfg = c;
    n_configs++;
  endtask

  // bursts of presses with random holds, occasional bounce and noise
  task automatic run_presses(input int n, input int hold_max, input int gap_max,
                             input int burst_max);
    int   stop_at, presses, hold, k;
    logic act;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      act = ~cur_cfg.idle_level;
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 10)) send_host(1'($urandom_range(0, 1)));
      end else begin
        presses = $urandom_range(1, burst_max);
        for (k = 0; k < presses; k++) begin
          hold = ($urandom_range(0, 4) == 0) ? $urandom_range(hold_max, 3 * hold_max)
                                              : $urandom_range(1, hold_max);
          if ($urandom_range(0, 5) == 0) begin
            // contact bounce ahead of the steady press
            send_host(act);
            send_host(~act);
          end
          repeat (hold) send_host(act);
          repeat ($urandom_range(1, gap_max)) send_host(~act);
        end
        repeat ($urandom_range(gap_max, 4 * gap_max)) send_host(~act);
      end
    end
  endtask

  task automatic test_directed();
    bcc_pkg::cfg_t c;
    c = '{idle_level: 1'b0, debounce_ms: 8'd0, single_press_max_ms: 16'd3,
          long_press_min_ms: 16'd6, release_action_ms: 16'd5,
          release_window_ms: 8'd3, poll_period_ms: 8'd1};
    load_config(c);
    send_tick(1'b0, bcc_pkg::CODE_NONE, 1'b1, '0);   // ack of none, zero threshold
    send_tick(1'b1, ACK_BAD_HIGH,       1'b0, '1);
    send_tick(1'b1, ACK_BAD_LOW,        1'b0, '1);
    send_tick(1'b0, bcc_pkg::CODE_MAX,  1'b0, '0);   // release: first click
    send_tick(1'b0, bcc_pkg::CODE_LONG, 1'b1, '1);   // threshold above duration
    send_tick(1'b0, bcc_pkg::CLICK_SAT, 1'b1, 32'd1);
    repeat (5) send_tick(1'b0, CODE_TWO_CLICKS, 1'b0, '0);
    send_tick(1'b0, CODE_ONE_CLICK, 1'b0, '0);
    send_tick(1'b0, CODE_ONE_CLICK, 1'b1, 32'hFFFF_0000);
    repeat (8) send_tick(1'b1, bcc_pkg::CODE_NONE, 1'b0, '0);
    send_tick(1'b0, bcc_pkg::CODE_MAX,  1'b0, '0);   // long release
    send_tick(1'b0, bcc_pkg::CODE_LONG, 1'b1, 32'd8);
    send_tick(1'b0, bcc_pkg::CODE_LONG, 1'b1, '0);
    wait_drained();
  endtask

  task automatic test_click_counting();
    bcc_pkg::cfg_t c;
    c = '{idle_level: 1'b0, debounce_ms: 8'd2, single_press_max_ms: 16'd8,
          long_press_min_ms: 16'd20, release_action_ms: 16'd12,
          release_window_ms: 8'd4, poll_period_ms: 8'd2};
    load_config(c);
    run_presses(420, 8, 6, 6);
    wait_drained();
  endtask

  task automatic test_long_press();
    bcc_pkg::cfg_t c;
    c = '{idle_level: 1'b1, debounce_ms: 8'd3, single_press_max_ms: 16'd5,
          long_press_min_ms: 16'd10, release_action_ms: 16'd8,
          release_window_ms: 8'd3, poll_period_ms: 8'd3};
    load_config(c);
    run_presses(280, 15, 8, 3);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    bcc_pkg::cfg_t c;
    c = '{idle_level: 1'b1, debounce_ms: 8'd255, single_press_max_ms: 16'hFFFF,
          long_press_min_ms: 16'hFFFF, release_action_ms: 16'hFFFF,
          release_window_ms: 8'd255, poll_period_ms: 8'd255};
    load_config(c);
    run_presses(200, 120, 60, 2);
    wait_drained();
    c = '{idle_level: 1'b0, debounce_ms: 8'd0, single_press_max_ms: 16'd0,
          long_press_min_ms: 16'd0, release_action_ms: 16'd0,
          release_window_ms: 8'd0, poll_period_ms: 8'd1};
    load_config(c);
    run_presses(150, 4, 4, 3);
    wait_drained();
    c = '{idle_level: 1'b0, debounce_ms: 8'd1, single_press_max_ms: 16'hFFFF,
          long_press_min_ms: 16'd0, release_action_ms: 16'hFFFF,
          release_window_ms: 8'd255, poll_period_ms: 8'd1};
    load_config(c);
    run_presses(150, 6, 5, 5);
    wait_drained();
  endtask

  task automatic test_random_settings();
    bcc_pkg::cfg_t c;
    int            k;
    for (k = 0; k < 3; k++) begin
      c.idle_level          = 1'($urandom_range(0, 1));
      c.debounce_ms         = 8'($urandom_range(0, 6));
      c.single_press_max_ms = 16'($urandom_range(2, 15));
      c.long_press_min_ms   = 16'($urandom_range(5, 40));
      c.release_action_ms   = 16'($urandom_range(3, 30));
      c.release_window_ms   = 8'($urandom_range(1, 8));
      c.poll_period_ms      = 8'($urandom_range(1, 4));
      load_config(c);
      run_presses(85, 12, 8, 4);
      wait_drained();
    end
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got = '{action_code, held_duration_ms, pressed, duration_cleared, action_matched};
      results_seen++;
      if (report_q.size() == 0) begin
        log_failure($sformatf("result beat %0d arrived with nothing expected", results_seen));
      end else begin
        want = report_q.pop_front();
        if (got !== want)
          log_failure($sformatf({"result %0d: expected code %0d dur %0d pressed %0b ",
            "cleared %0b matched %0b, got code %0d dur %0d pressed %0b cleared %0b ",
            "matched %0b"}, results_seen, want.action_code, want.held_duration_ms,
            want.pressed, want.duration_cleared, want.action_matched, got.action_code,
            got.held_duration_ms, got.pressed, got.duration_cleared, got.action_matched));
      end
    end
    stall_phase <= stall_phase + 6'd1;
    if (stall_phase == '0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= 1'($urandom_range(0, 1));
      2'd2:    out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (stall_phase[1:0] != 2'd3);
    endcase
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    reset_prediction();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_click_counting();
    test_long_press();
    test_register_extremes();
    test_random_settings();
    wait_drained();
    repeat (10) @(posedge clk);
    if (report_q.size() != 0)
      log_failure($sformatf("%0d expected results never arrived", report_q.size()));
    $display("Run covered %0d ticks over %0d register settings, %0d results checked.",
             items_sent, n_configs, results_seen);
    $display("Acked %0d click actions and %0d long presses; %0d held durations cleared.",
             n_click_acks, n_long_acks, n_clears);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
